### hdl/qfk_pkg.sv
// Shared types, constants and saturation helpers for the quadratic-fit Kalman estimator.
// Used by quadratic_fit_kalman_filter_top and its testbench; no dependencies.
`default_nettype none
package qfk_pkg;

    localparam int STATE_SIZE = 3;
    localparam int NOISE_W    = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int COV_W      = 48;
    localparam int COEF_W     = 32;
    localparam int WIDE_W     = 62;
    localparam int DX_W       = 40;
    localparam int VAL_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_NOISE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 1'b1;

    localparam logic OP_OBSERVE  = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [NOISE_W-1:0] PN_RESET = 31'd66;
    localparam logic [NOISE_W-1:0] RN_RESET = 31'd65536;
    localparam logic signed [COV_W-1:0] COV_DIAG_RESET = 48'sd1000 <<< 24;
    localparam logic signed [VAL_W-1:0] ONE_Q16 = 64'sd65536;

    typedef struct packed {
        logic               op;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic [1:0]         status;
    } out_item_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [65:0] v,
                                                        input int w);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = (66'sd1 <<< (w - 1)) - 66'sd1;
        lo = -(66'sd1 <<< (w - 1));
        if (v > hi)
            return hi[VAL_W-1:0];
        else if (v < lo)
            return lo[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    function automatic logic sat_hit(input logic signed [65:0] v, input int w);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = (66'sd1 <<< (w - 1)) - 66'sd1;
        lo = -(66'sd1 <<< (w - 1));
        return (v > hi) || (v < lo);
    endfunction

endpackage
`default_nettype wire

### hdl/qfk_muldiv.sv
// Shared multiply-divide unit: round(a*b/den), ties away from zero, clamped to 62 bits.
// Four 31x31 partial products, then a shift (den 2^16) or a 62-step restoring divide.
// No dependencies.
`default_nettype none
module qfk_muldiv (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     use_shift,
    input  wire logic signed [63:0]       a,
    input  wire logic signed [63:0]       b,
    input  wire logic [61:0]              den,
    output logic                          done,
    output logic signed [63:0]            q,
    output logic                          ovf
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_RND  = 3'd2;
    localparam logic [2:0] PH_CHK  = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;
    localparam logic [2:0] PH_FIN  = 3'd5;

    logic [2:0]   ph_reg, ph_next;
    logic [1:0]   k_reg, k_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [61:0]  ua_reg, ua_next, ub_reg, ub_next;
    logic [61:0]  den_reg, den_next;
    logic         neg_reg, neg_next, shf_reg, shf_next, dovf_reg, dovf_next;
    logic [123:0] n_reg, n_next;
    logic [61:0]  rem_reg, rem_next;
    logic [61:0]  quo_reg, quo_next;

    logic [63:0]  abs_a, abs_b;
    logic [30:0]  pa, pb;
    logic [61:0]  pp;
    logic [123:0] pp_sh;
    logic [62:0]  trial;
    logic [61:0]  lim, mag;
    logic         big;

    assign abs_a = a[63] ? 64'(-a) : 64'(a);
    assign abs_b = b[63] ? 64'(-b) : 64'(b);
    assign pa    = k_reg[1] ? ua_reg[61:31] : ua_reg[30:0];
    assign pb    = k_reg[0] ? ub_reg[61:31] : ub_reg[30:0];
    assign pp    = pa * pb;
    assign trial = {rem_reg, n_reg[61]};

    always_comb
    begin
        unique case (k_reg)
            2'd0:    pp_sh = 124'(pp);
            2'd3:    pp_sh = 124'(pp) << 62;
            default: pp_sh = 124'(pp) << 31;
        endcase
    end

    always_comb
    begin
        ph_next   = ph_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shf_next  = shf_reg;
        dovf_next = dovf_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    ua_next   = abs_a[61:0];
                    ub_next   = abs_b[61:0];
                    neg_next  = a[63] ^ b[63];
                    shf_next  = use_shift;
                    den_next  = den;
                    n_next    = '0;
                    k_next    = '0;
                    dovf_next = 1'b0;
                    ph_next   = PH_MUL;
                end
            end
            PH_MUL:
            begin
                n_next = n_reg + pp_sh;
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                    ph_next = PH_RND;
            end
            PH_RND:
            begin
                n_next  = n_reg + (shf_reg ? 124'd32768 : 124'(den_reg >> 1));
                ph_next = shf_reg ? PH_FIN : PH_CHK;
            end
            PH_CHK:
            begin
                if (n_reg[123:62] >= den_reg)
                begin
                    dovf_next = 1'b1;
                    ph_next   = PH_FIN;
                end
                else
                begin
                    rem_next = n_reg[123:62];
                    quo_next = '0;
                    cnt_next = 6'd61;
                    ph_next  = PH_DIV;
                end
            end
            PH_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 62'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[60:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[61:0];
                    quo_next = {quo_reg[60:0], 1'b0};
                end
                n_next   = n_reg << 1;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    ph_next = PH_FIN;
            end
            PH_FIN:
                ph_next = PH_IDLE;
            default:
                ph_next = PH_IDLE;
        endcase
    end

    // Magnitude limit: 2^61 for a negative result, 2^61-1 otherwise
    assign lim = neg_reg ? {1'b1, 61'd0} : {1'b0, {61{1'b1}}};

    always_comb
    begin
        if (shf_reg)
        begin
            big = (|n_reg[123:78]) || (n_reg[77:16] > lim);
            mag = n_reg[77:16];
        end
        else
        begin
            big = dovf_reg || (quo_reg > lim);
            mag = quo_reg;
        end
    end

    assign done = (ph_reg == PH_FIN);
    assign ovf  = big;
    assign q    = neg_reg ? -$signed(64'(big ? lim : mag)) : $signed(64'(big ? lim : mag));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= PH_IDLE;
        else
            ph_reg <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        shf_reg  <= shf_next;
        dovf_reg <= dovf_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

endmodule
`default_nettype wire

### hdl/quadratic_fit_kalman_filter_top.sv
// Top level of the quadratic-fit Kalman estimator: sequencer, state and output register.
// Depends on qfk_pkg and qfk_muldiv.
//
// Usage:
//   in_valid/in_ready/in_item carry one item (op, x_value, y_value); a transfer
//   happens when both valid and ready are high. out_valid/out_ready/out_item
//   return one result per item (value, coef_a..coef_c, status).
//   cfg_write/cfg_index/cfg_data write the diagonal noise (0) or the measurement
//   noise (1) at once; write only while the block is idle.
// Sequencing:
//   All multiplies and divides run through one shared multiply-divide unit. A
//   multiply by a Q16.16 operand ends in a rounding shift; a divide by S runs
//   through the 62 one-bit restoring divide steps. An observe uses twelve divides.
//   in_ready is high only while the sequencer is idle; one item is processed at a time.
// Reset: coefficients zero, covariance 1000 times identity, noise registers at
//   their defaults, no result pending; no clearing pass is needed.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile and holds its own result back until the register frees.
`default_nettype none
module quadratic_fit_kalman_filter_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire qfk_pkg::in_item_t                  in_item,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output qfk_pkg::out_item_t                      out_item,
    input  wire logic                               cfg_write,
    input  wire logic [qfk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [qfk_pkg::NOISE_W-1:0]        cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_H0    = 4'd1;
    localparam logic [3:0] S_NOISE = 4'd2;
    localparam logic [3:0] S_U     = 4'd3;
    localparam logic [3:0] S_S     = 4'd4;
    localparam logic [3:0] S_E0    = 4'd5;
    localparam logic [3:0] S_E1    = 4'd6;
    localparam logic [3:0] S_E2    = 4'd7;
    localparam logic [3:0] S_DX    = 4'd8;
    localparam logic [3:0] S_DP    = 4'd9;
    localparam logic [3:0] S_V0    = 4'd10;
    localparam logic [3:0] S_V1    = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0] st_reg, st_next;
    logic [1:0] i_reg, i_next, j_reg, j_next;
    logic       launch_reg, launch_next;
    logic       sat_reg, sat_next, skip_reg, skip_next;
    logic       op_reg, op_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic signed [63:0] h0_reg, h0_next, s_reg, s_next, t_reg, t_next, e_reg, e_next;
    logic signed [63:0] u_reg [qfk_pkg::STATE_SIZE];
    logic signed [63:0] u_next [qfk_pkg::STATE_SIZE];
    logic signed [31:0] coef_reg [qfk_pkg::STATE_SIZE];
    logic signed [31:0] coef_next [qfk_pkg::STATE_SIZE];
    logic signed [47:0] cov_reg [qfk_pkg::STATE_SIZE*qfk_pkg::STATE_SIZE];
    logic signed [47:0] cov_next [qfk_pkg::STATE_SIZE*qfk_pkg::STATE_SIZE];
    logic [qfk_pkg::NOISE_W-1:0] pn_reg, rn_reg;
    logic       out_valid_reg, out_valid_next;
    qfk_pkg::out_item_t out_reg, out_next;

    logic               md_req, md_start, md_shift, md_done, md_ovf;
    logic signed [63:0] md_a, md_b, md_q;
    logic [3:0]         cidx;
    logic signed [63:0] hj, hi;
    logic signed [65:0] acc, dsum;
    logic signed [63:0] q40;

    function automatic logic signed [63:0] h_at(input logic [1:0] k,
                                                input logic signed [63:0] h0,
                                                input logic signed [31:0] x);
        case (k)
            2'd0:    return h0;
            2'd1:    return 64'(x);
            default: return qfk_pkg::ONE_Q16;
        endcase
    endfunction

    assign cidx = 4'({i_reg, 1'b0}) + 4'(i_reg) + 4'(j_reg);
    assign hj   = h_at(j_reg, h0_reg, x_reg);
    assign hi   = h_at(i_reg, h0_reg, x_reg);

    assign md_req = (st_reg == S_H0) || (st_reg == S_U) || (st_reg == S_S) ||
                    (st_reg == S_E0) || (st_reg == S_E1) || (st_reg == S_DX) ||
                    (st_reg == S_DP) || (st_reg == S_V0) || (st_reg == S_V1);
    assign md_start = md_req && !launch_reg;

    always_comb
    begin
        md_a     = '0;
        md_b     = '0;
        md_shift = 1'b1;
        unique case (st_reg)
            S_H0:
            begin
                md_a = 64'(x_reg);
                md_b = 64'(x_reg);
            end
            S_U:
            begin
                md_a = 64'(cov_reg[cidx]);
                md_b = hj;
            end
            S_S:
            begin
                md_a = hi;
                md_b = u_reg[i_reg];
            end
            S_E0, S_V0:
            begin
                md_a = 64'(coef_reg[0]);
                md_b = h0_reg;
            end
            S_E1, S_V1:
            begin
                md_a = 64'(coef_reg[1]);
                md_b = 64'(x_reg);
            end
            S_DX:
            begin
                md_a     = u_reg[i_reg];
                md_b     = e_reg;
                md_shift = 1'b0;
            end
            S_DP:
            begin
                md_a     = u_reg[i_reg];
                md_b     = u_reg[j_reg];
                md_shift = 1'b0;
            end
            default:
            begin
                md_a = '0;
            end
        endcase
    end

    qfk_muldiv u_muldiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (md_start),
        .use_shift (md_shift),
        .a         (md_a),
        .b         (md_b),
        .den       (s_reg[61:0]),
        .done      (md_done),
        .q         (md_q),
        .ovf       (md_ovf)
    );

    assign in_ready  = (st_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        st_next        = st_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sat_next       = sat_reg;
        skip_next      = skip_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        h0_next        = h0_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        e_next         = e_reg;
        u_next         = u_reg;
        coef_next      = coef_reg;
        cov_next       = cov_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        launch_next    = md_done ? 1'b0 : (md_start ? 1'b1 : launch_reg);
        acc            = '0;
        dsum           = '0;
        q40            = '0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_item.op;
                    x_next    = in_item.x_value;
                    y_next    = in_item.y_value;
                    sat_next  = 1'b0;
                    skip_next = 1'b0;
                    st_next   = S_H0;
                end
            end
            S_H0:
            begin
                if (md_done)
                begin
                    h0_next  = md_q;
                    sat_next = sat_reg | md_ovf;
                    st_next  = (op_reg == qfk_pkg::OP_EVALUATE) ? S_V0 : S_NOISE;
                end
            end
            S_NOISE:
            begin
                for (int d = 0; d < qfk_pkg::STATE_SIZE; d++)
                begin
                    dsum = 66'(cov_reg[d*(qfk_pkg::STATE_SIZE+1)]) + 66'({pn_reg, 8'd0});
                    cov_next[d*(qfk_pkg::STATE_SIZE+1)] =
                        48'(qfk_pkg::sat_val(dsum, qfk_pkg::COV_W));
                    sat_next = sat_next | qfk_pkg::sat_hit(dsum, qfk_pkg::COV_W);
                end
                s_next  = 64'({rn_reg, 8'd0});
                i_next  = '0;
                j_next  = '0;
                st_next = S_U;
            end
            S_U:
            begin
                if (md_done)
                begin
                    acc = 66'(md_q) + ((j_reg == 2'd0) ? 66'sd0 : 66'(u_reg[i_reg]));
                    u_next[i_reg] = qfk_pkg::sat_val(acc, qfk_pkg::WIDE_W);
                    sat_next = sat_reg | md_ovf | qfk_pkg::sat_hit(acc, qfk_pkg::WIDE_W);
                    j_next = (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                    if (j_reg == 2'd2)
                    begin
                        i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                        if (i_reg == 2'd2)
                            st_next = S_S;
                    end
                end
            end
            S_S:
            begin
                if (md_done)
                begin
                    acc      = 66'(s_reg) + 66'(md_q);
                    s_next   = qfk_pkg::sat_val(acc, qfk_pkg::WIDE_W);
                    sat_next = sat_reg | md_ovf | qfk_pkg::sat_hit(acc, qfk_pkg::WIDE_W);
                    i_next   = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                    if (i_reg == 2'd2)
                        st_next = S_E0;
                end
            end
            S_E0, S_V0:
            begin
                if (md_done)
                begin
                    acc      = 66'(coef_reg[2]) + 66'(md_q);
                    t_next   = qfk_pkg::sat_val(acc, qfk_pkg::WIDE_W);
                    sat_next = sat_reg | md_ovf | qfk_pkg::sat_hit(acc, qfk_pkg::WIDE_W);
                    st_next  = (st_reg == S_E0) ? S_E1 : S_V1;
                end
            end
            S_E1, S_V1:
            begin
                if (md_done)
                begin
                    acc      = 66'(t_reg) + 66'(md_q);
                    t_next   = qfk_pkg::sat_val(acc, qfk_pkg::WIDE_W);
                    sat_next = sat_reg | md_ovf | qfk_pkg::sat_hit(acc, qfk_pkg::WIDE_W);
                    st_next  = (st_reg == S_E1) ? S_E2 : S_FIN;
                end
            end
            S_E2:
            begin
                acc      = 66'(y_reg) - 66'(t_reg);
                e_next   = qfk_pkg::sat_val(acc, qfk_pkg::WIDE_W);
                sat_next = sat_reg | qfk_pkg::sat_hit(acc, qfk_pkg::WIDE_W);
                i_next   = '0;
                j_next   = '0;
                if (s_reg <= 64'sd0)
                begin
                    skip_next = 1'b1;
                    st_next   = S_V0;
                end
                else
                    st_next = S_DX;
            end
            S_DX:
            begin
                if (md_done)
                begin
                    q40  = qfk_pkg::sat_val(66'(md_q), qfk_pkg::DX_W);
                    acc  = 66'(coef_reg[i_reg]) + 66'(q40);
                    coef_next[i_reg] = 32'(qfk_pkg::sat_val(acc, qfk_pkg::COEF_W));
                    sat_next = sat_reg | md_ovf | qfk_pkg::sat_hit(66'(md_q), qfk_pkg::DX_W)
                               | qfk_pkg::sat_hit(acc, qfk_pkg::COEF_W);
                    i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                    if (i_reg == 2'd2)
                        st_next = S_DP;
                end
            end
            S_DP:
            begin
                if (md_done)
                begin
                    acc = 66'(cov_reg[cidx]) - 66'(md_q);
                    cov_next[cidx] = 48'(qfk_pkg::sat_val(acc, qfk_pkg::COV_W));
                    sat_next = sat_reg | md_ovf | qfk_pkg::sat_hit(acc, qfk_pkg::COV_W);
                    j_next = (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                    if (j_reg == 2'd2)
                    begin
                        i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                        if (i_reg == 2'd2)
                            st_next = S_V0;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.value  = 32'(qfk_pkg::sat_val(66'(t_reg), qfk_pkg::COEF_W));
                    out_next.coef_a = coef_reg[0];
                    out_next.coef_b = coef_reg[1];
                    out_next.coef_c = coef_reg[2];
                    if (sat_reg || qfk_pkg::sat_hit(66'(t_reg), qfk_pkg::COEF_W))
                        out_next.status = qfk_pkg::ST_SAT;
                    else if (skip_reg)
                        out_next.status = qfk_pkg::ST_SKIP;
                    else
                        out_next.status = qfk_pkg::ST_OK;
                    out_valid_next = 1'b1;
                    st_next        = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pn_reg        <= qfk_pkg::PN_RESET;
            rn_reg        <= qfk_pkg::RN_RESET;
            for (int k = 0; k < qfk_pkg::STATE_SIZE; k++)
                coef_reg[k] <= '0;
            for (int row = 0; row < qfk_pkg::STATE_SIZE; row++)
                for (int col = 0; col < qfk_pkg::STATE_SIZE; col++)
                    cov_reg[row*qfk_pkg::STATE_SIZE + col] <= (row == col) ?
                        qfk_pkg::COV_DIAG_RESET : 48'sd0;
        end
        else
        begin
            st_reg        <= st_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            coef_reg      <= coef_next;
            cov_reg       <= cov_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    qfk_pkg::CFG_DIAG_NOISE: pn_reg <= cfg_data;
                    qfk_pkg::CFG_MEAS_NOISE: rn_reg <= cfg_data;
                    default:                 pn_reg <= pn_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        sat_reg  <= sat_next;
        skip_reg <= skip_next;
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        h0_reg   <= h0_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        e_reg    <= e_next;
        u_reg    <= u_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready after taking an item");

    a_update_needs_pos_s: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DX || st_reg == S_DP) |-> (s_reg > 64'sd0 && !skip_reg))
        else $error("gain update running with nonpositive S");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == qfk_pkg::ST_OK ||
                           out_reg.status == qfk_pkg::ST_SKIP ||
                           out_reg.status == qfk_pkg::ST_SAT))
        else $error("illegal status code");
`endif

endmodule
`default_nettype wire

### bench/tb_quadratic_fit_kalman_filter_top.sv
// Self-checking testbench for quadratic_fit_kalman_filter_top: an in-bench predictor of the
// coefficient estimate, random valid/ready idling and an output hold-off. Depends on qfk_pkg.
`timescale 1ns / 100ps
module tb_quadratic_fit_kalman_filter_top;

    localparam int CYCLE_LIMIT = 6000000;
    localparam longint Q16 = 65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    qfk_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    qfk_pkg::out_item_t out_item;
    logic cfg_write = 1'b0;
    logic [qfk_pkg::CFG_IDX_W-1:0] cfg_index = qfk_pkg::CFG_DIAG_NOISE;
    logic [qfk_pkg::NOISE_W-1:0] cfg_data = '0;

    // predictor state
    logic [qfk_pkg::NOISE_W-1:0] proc_noise;
    logic [qfk_pkg::NOISE_W-1:0] obs_noise;
    longint coef [qfk_pkg::STATE_SIZE];
    longint cov [qfk_pkg::STATE_SIZE*qfk_pkg::STATE_SIZE];
    bit sat_seen;

    qfk_pkg::out_item_t expected_results [$];
    int mismatches = 0;
    int cycles = 0;
    bit no_idle = 0;
    int hold_request = 0;

    quadratic_fit_kalman_filter_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quadratic_fit_kalman_filter_top: mismatch");
            $finish;
        end
    end

    function automatic longint clamp(longint v, int w);
        longint lim;
        lim = longint'(1) <<< (w - 1);
        if (v > lim - 1)
        begin
            sat_seen = 1;
            return lim - 1;
        end
        if (v < -lim)
        begin
            sat_seen = 1;
            return -lim;
        end
        return v;
    endfunction

    // round(a*b/den), ties away from zero, clamped to w bits
    function automatic longint scale(longint a, longint b, logic [63:0] den, int w);
        logic [127:0] n;
        logic [127:0] q;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] lim;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        n = {64'd0, ua} * {64'd0, ub};
        n = n + {64'd0, den >> 1};
        q = n / {64'd0, den};
        lim = (64'd1 << (w - 1)) - (neg ? 64'd0 : 64'd1);
        if (q > {64'd0, lim})
        begin
            sat_seen = 1;
            q = {64'd0, lim};
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint fitted_at(longint h0, longint h1);
        longint s;
        s = coef[2];
        s = clamp(s + scale(coef[0], h0, Q16, qfk_pkg::WIDE_W), qfk_pkg::WIDE_W);
        s = clamp(s + scale(coef[1], h1, Q16, qfk_pkg::WIDE_W), qfk_pkg::WIDE_W);
        return s;
    endfunction

    function automatic qfk_pkg::out_item_t estimate_step(qfk_pkg::in_item_t it);
        longint x;
        longint y;
        longint h [qfk_pkg::STATE_SIZE];
        longint u [qfk_pkg::STATE_SIZE];
        longint s;
        longint e;
        longint dx;
        longint dp;
        bit skip;
        qfk_pkg::out_item_t r;
        sat_seen = 0;
        skip = 0;
        x = it.x_value;
        y = it.y_value;
        h[0] = scale(x, x, Q16, qfk_pkg::WIDE_W);
        h[1] = x;
        h[2] = Q16;
        if (it.op == qfk_pkg::OP_OBSERVE)
        begin
            for (int i = 0; i < qfk_pkg::STATE_SIZE; i++)
                cov[i*4] = clamp(cov[i*4] + (longint'(proc_noise) <<< 8), qfk_pkg::COV_W);
            for (int i = 0; i < qfk_pkg::STATE_SIZE; i++)
            begin
                u[i] = 0;
                for (int j = 0; j < qfk_pkg::STATE_SIZE; j++)
                    u[i] = clamp(u[i] + scale(cov[i*3+j], h[j], Q16, qfk_pkg::WIDE_W),
                                 qfk_pkg::WIDE_W);
            end
            s = longint'(obs_noise) <<< 8;
            for (int i = 0; i < qfk_pkg::STATE_SIZE; i++)
                s = clamp(s + scale(h[i], u[i], Q16, qfk_pkg::WIDE_W), qfk_pkg::WIDE_W);
            e = clamp(y - fitted_at(h[0], h[1]), qfk_pkg::WIDE_W);
            if (s <= 0)
                skip = 1;
            else
            begin
                for (int i = 0; i < qfk_pkg::STATE_SIZE; i++)
                begin
                    dx = scale(u[i], e, s, qfk_pkg::WIDE_W);
                    coef[i] = clamp(clamp(coef[i] + clamp(dx, qfk_pkg::DX_W), 63),
                                    qfk_pkg::COEF_W);
                end
                for (int i = 0; i < qfk_pkg::STATE_SIZE; i++)
                    for (int j = 0; j < qfk_pkg::STATE_SIZE; j++)
                    begin
                        dp = scale(u[i], u[j], s, qfk_pkg::WIDE_W);
                        cov[i*3+j] = clamp(clamp(cov[i*3+j] - dp, qfk_pkg::WIDE_W),
                                           qfk_pkg::COV_W);
                    end
            end
        end
        r.value = 32'(clamp(fitted_at(h[0], h[1]), qfk_pkg::COEF_W));
        r.coef_a = 32'(coef[0]);
        r.coef_b = 32'(coef[1]);
        r.coef_c = 32'(coef[2]);
        r.status = sat_seen ? qfk_pkg::ST_SAT : (skip ? qfk_pkg::ST_SKIP : qfk_pkg::ST_OK);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_item(input logic op, input longint x, input longint y);
        int gap;
        qfk_pkg::in_item_t it;
        it.op = op;
        it.x_value = x[31:0];
        it.y_value = y[31:0];
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(estimate_step(it));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_noise(input logic [qfk_pkg::CFG_IDX_W-1:0] idx,
                               input logic [qfk_pkg::NOISE_W-1:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == qfk_pkg::CFG_DIAG_NOISE)
            proc_noise = v;
        else
            obs_noise = v;
    endtask

    // receiver: random ready, occasional long stalls, hold-off on request
    always @(negedge clk)
    begin
        int hold;
        if (hold_request > 0)
        begin
            hold = hold_request;
            hold_request = 0;
        end
        if (hold > 0)
        begin
            hold--;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 299) == 0)
        begin
            hold = $urandom_range(20, 300);
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) < 75);
    end

    always @(posedge clk)
    begin
        qfk_pkg::out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %p", out_item);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r !== out_item)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", exp_r, out_item);
                end
            end
        end
    end

    task automatic test_evaluate_after_reset();
        send_item(qfk_pkg::OP_EVALUATE, 0, 0);
        send_item(qfk_pkg::OP_EVALUATE, 32'h7FFFFFFF, 0);
        send_item(qfk_pkg::OP_EVALUATE, -longint'(32'h80000000), 32'h7FFFFFFF);
        drain();
    endtask

    task automatic test_directed_extremes();
        send_item(qfk_pkg::OP_OBSERVE, Q16, 3 * Q16);
        send_item(qfk_pkg::OP_OBSERVE, -Q16, Q16);
        send_item(qfk_pkg::OP_OBSERVE, 2 * Q16, 9 * Q16);
        send_item(qfk_pkg::OP_EVALUATE, 3 * Q16, 0);
        send_item(qfk_pkg::OP_OBSERVE, 0, 32'h7FFFFFFF);
        send_item(qfk_pkg::OP_OBSERVE, 0, -longint'(32'h80000000));
        send_item(qfk_pkg::OP_OBSERVE, 32'h7FFFFFFF, -longint'(32'h80000000));
        send_item(qfk_pkg::OP_OBSERVE, -longint'(32'h80000000), 32'h7FFFFFFF);
        send_item(qfk_pkg::OP_EVALUATE, 32'h7FFFFFFF, 0);
        send_item(qfk_pkg::OP_EVALUATE, -1, 0);
        drain();
    endtask

    // zero noise and one repeated abscissa drive S towards zero
    task automatic test_degenerate_innovation();
        write_noise(qfk_pkg::CFG_DIAG_NOISE, '0);
        write_noise(qfk_pkg::CFG_MEAS_NOISE, '0);
        for (int i = 0; i < 8; i++)
            send_item(qfk_pkg::OP_OBSERVE, 5 * Q16, i * Q16);
        send_item(qfk_pkg::OP_EVALUATE, 5 * Q16, 0);
        drain();
    endtask

    task automatic test_random_fit(input logic [qfk_pkg::NOISE_W-1:0] pn,
                                   input logic [qfk_pkg::NOISE_W-1:0] rn,
                                   input int count);
        longint a;
        longint b;
        longint c;
        longint x;
        longint y;
        int r;
        write_noise(qfk_pkg::CFG_DIAG_NOISE, pn);
        write_noise(qfk_pkg::CFG_MEAS_NOISE, rn);
        a = longint'($urandom_range(0, 4 * Q16)) - 2 * Q16;
        b = longint'($urandom_range(0, 8 * Q16)) - 4 * Q16;
        c = longint'($urandom_range(0, 32 * Q16)) - 16 * Q16;
        for (int i = 0; i < count; i++)
        begin
            no_idle = (i % 100) >= 80;
            r = $urandom_range(0, 99);
            x = longint'($urandom_range(0, 16 * Q16)) - 8 * Q16;
            if (r < 6)
                send_item(1'($urandom_range(0, 1)), $signed($urandom), $signed($urandom));
            else if (r < 18)
                send_item(qfk_pkg::OP_EVALUATE, x, $signed($urandom));
            else
            begin
                y = ((a * ((x * x) >>> 16)) >>> 16) + ((b * x) >>> 16) + c
                    + longint'($urandom_range(0, Q16)) - Q16 / 2;
                send_item(qfk_pkg::OP_OBSERVE, x, y);
            end
        end
        no_idle = 0;
        drain();
    endtask

    task automatic test_output_hold_off();
        hold_request = 3000;
        no_idle = 1;
        for (int i = 0; i < 5; i++)
            send_item(qfk_pkg::OP_OBSERVE, (i + 1) * Q16, i * Q16);
        no_idle = 0;
        drain();
    endtask

    initial
    begin
        proc_noise = qfk_pkg::PN_RESET;
        obs_noise = qfk_pkg::RN_RESET;
        for (int i = 0; i < qfk_pkg::STATE_SIZE; i++)
            coef[i] = 0;
        for (int i = 0; i < qfk_pkg::STATE_SIZE*qfk_pkg::STATE_SIZE; i++)
            cov[i] = (i % 4 == 0) ? longint'(qfk_pkg::COV_DIAG_RESET) : 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_evaluate_after_reset();
        test_directed_extremes();
        test_degenerate_innovation();
        test_random_fit(qfk_pkg::PN_RESET, qfk_pkg::RN_RESET, 200);
        test_output_hold_off();
        test_random_fit('0, 31'h7FFFFFFF, 150);
        test_random_fit(31'h7FFFFFFF, '0, 150);
        test_random_fit(31'd1000, 31'd4 << 16, 160);
        test_random_fit(31'($urandom), 31'($urandom), 150);
        if (mismatches == 0)
            $display("quadratic_fit_kalman_filter_top: match");
        else
            $display("quadratic_fit_kalman_filter_top: mismatch");
        $finish;
    end

endmodule
